[sv/jazw_pkg.sv]
`timescale 1ns / 1ps
// Package for the joint angle zero, wrap and unwrap unit.
// Holds the payload structs, field widths and fixed-point constants; no dependencies.
package jazw_pkg;

	localparam int NUM_JOINTS = 6;
	localparam int ZP_COUNT   = 6;
	localparam int JOINT_W    = 3;
	localparam int DEG_W      = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int ANGLE_W    = 32;
	localparam int RAD_W      = 19;
	localparam int DELTA_W    = RAD_W + 2;
	localparam int DIFF_W     = DEG_W + 2;

	localparam int DEG_Q8_180 = 46080;
	localparam int DEG_Q8_360 = 92160;
	localparam int PI_Q16     = 205887;
	localparam int TWO_PI_Q16 = 411774;
	localparam int ROUND_HALF = DEG_Q8_180 / 2;

	// Division by 46080 is a shift by 10 followed by division by 45.
	localparam int PROD_W     = 35;
	localparam int PRE_SHIFT  = 10;
	localparam int QUOT_IN_W  = PROD_W - PRE_SHIFT;
	localparam int DIV_SHIFT  = 31;
	localparam int DIV_MULT   = 47721859;
	localparam int QMUL_W     = QUOT_IN_W + 26;

	localparam logic [JOINT_W-1:0] LAST_JOINT = JOINT_W'(NUM_JOINTS - 1);

	typedef struct packed {
		logic [JOINT_W-1:0] joint;
		logic [DEG_W-1:0]   raw_degrees;
	} in_t;

	typedef struct packed {
		logic [JOINT_W-1:0]        joint_out;
		logic signed [ANGLE_W-1:0] angle_radians;
		logic                      negative;
	} out_t;

endpackage

[sv/jazw_unwrap.sv]
`timescale 1ns / 1ps
// Phase unwrap of the last joint's angle with a saturating 32-bit accumulator.
// Depends on jazw_pkg.
module jazw_unwrap (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              update,
	input  logic [jazw_pkg::RAD_W-1:0]        wrapped,
	output logic signed [jazw_pkg::ANGLE_W-1:0] result
);
	import jazw_pkg::*;

	logic signed [ANGLE_W-1:0] prev_q;
	logic [RAD_W-1:0]          prev_wrapped_q;
	logic                      started_q;
	logic signed [DELTA_W-1:0] delta_raw;
	logic signed [DELTA_W-1:0] delta;
	logic signed [ANGLE_W:0]   sum;

	always_comb begin
		delta_raw = signed'(DELTA_W'(wrapped)) - signed'(DELTA_W'(prev_wrapped_q));
		if (delta_raw > DELTA_W'(PI_Q16)) begin
			delta = delta_raw - DELTA_W'(TWO_PI_Q16);
		end else if (delta_raw < -DELTA_W'(PI_Q16)) begin
			delta = delta_raw + DELTA_W'(TWO_PI_Q16);
		end else begin
			delta = delta_raw;
		end
		sum = (ANGLE_W + 1)'(prev_q) + (ANGLE_W + 1)'(delta);
		if (!started_q) begin
			result = signed'(ANGLE_W'(wrapped));
		end else if (sum[ANGLE_W] != sum[ANGLE_W-1]) begin
			result = sum[ANGLE_W] ? {1'b1, {(ANGLE_W - 1){1'b0}}}
				: {1'b0, {(ANGLE_W - 1){1'b1}}};
		end else begin
			result = sum[ANGLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q         <= '0;
			prev_wrapped_q <= '0;
			started_q      <= 1'b0;
		end else if (update) begin
			prev_q         <= result;
			prev_wrapped_q <= wrapped;
			started_q      <= 1'b1;
		end
	end

endmodule

[sv/joint_angle_zero_wrap_unwrap_unit.sv]
`timescale 1ns / 1ps
// Joint angle unit: zero offset, wrap to +-180 degrees, conversion to Q16 radians and
// unwrap of the last joint. Depends on jazw_pkg and jazw_unwrap.
//
// The unit accepts one transaction per clock while the output is not stalled and
// returns one result transaction for each, in order. The path is an input register, a
// register after the degree-to-radian multiply, a register after the divide-by-constant
// multiply, and the output register; the unwrap state of the last joint is read and
// updated in the final stage, in the same cycle. The user must write zero points through
// the configuration port only while no transaction is in flight; the unit itself does
// not enforce this. Indexes beyond the six registers are ignored.
module joint_angle_zero_wrap_unwrap_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  jazw_pkg::in_t                  in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output jazw_pkg::out_t                 out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [jazw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [jazw_pkg::DEG_W-1:0]     cfg_data
);
	import jazw_pkg::*;

	logic [DEG_W-1:0]       zp_q [ZP_COUNT];

	logic                   v_s1, v_s2, v_s3, out_valid_q;
	in_t                    in_s1;
	logic [JOINT_W-1:0]     joint_s2, joint_s3;
	logic [QUOT_IN_W-1:0]   quot_in_s2;
	logic [RAD_W-1:0]       rad_s3;
	out_t                   out_data_q;

	logic                   en1, en2, en3, en_out;
	logic [DEG_W-1:0]       zp_sel;
	logic signed [DIFF_W-1:0] diff;
	logic signed [DIFF_W-1:0] diff_wrapped;
	logic [DEG_W-1:0]       deg;
	logic [PROD_W-1:0]      prod;
	logic [QMUL_W-1:0]      qmul;
	logic [RAD_W-1:0]       inv;
	logic                   is_last;
	logic signed [ANGLE_W-1:0] unwrap_result;
	logic signed [ANGLE_W-1:0] angle;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ZP_COUNT; i++) begin
				zp_q[i] <= '0;
			end
		end else if (cfg_valid && (cfg_index < CFG_IDX_W'(ZP_COUNT))) begin
			zp_q[cfg_index] <= cfg_data;
		end
	end

	always_comb begin
		en_out   = !out_valid_q || out_ready;
		en3      = !v_s3 || en_out;
		en2      = !v_s2 || en3;
		en1      = !v_s1 || en2;
	end

	assign in_ready = en1;

	always_comb begin
		zp_sel = '0;
		if ((in_s1.joint < JOINT_W'(NUM_JOINTS)) && (in_s1.joint < JOINT_W'(ZP_COUNT))) begin
			zp_sel = zp_q[in_s1.joint];
		end
		diff = signed'(DIFF_W'(in_s1.raw_degrees)) - signed'(DIFF_W'(zp_sel));
		if (diff < -DIFF_W'(DEG_Q8_180)) begin
			diff_wrapped = diff + DIFF_W'(DEG_Q8_360);
		end else if (diff > DIFF_W'(DEG_Q8_180)) begin
			diff_wrapped = diff - DIFF_W'(DEG_Q8_360);
		end else begin
			diff_wrapped = diff;
		end
		deg  = DEG_W'(diff_wrapped + DIFF_W'(DEG_Q8_180));
		prod = PROD_W'(deg) * PROD_W'(PI_Q16) + PROD_W'(ROUND_HALF);
	end

	assign qmul = QMUL_W'(quot_in_s2) * QMUL_W'(DIV_MULT);

	always_comb begin
		is_last = (joint_s3 == LAST_JOINT);
		if (rad_s3 == '0) begin
			inv = '0;
		end else begin
			inv = RAD_W'(TWO_PI_Q16) - rad_s3;
		end
		if (is_last) begin
			angle = unwrap_result;
		end else begin
			angle = signed'(ANGLE_W'(rad_s3));
		end
	end

	jazw_unwrap u_unwrap (
		.clk     (clk),
		.arst_n  (arst_n),
		.update  (v_s3 && en_out && is_last),
		.wrapped (inv),
		.result  (unwrap_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en_out) begin
				out_valid_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			in_s1 <= in_data;
		end
		if (en2 && v_s1) begin
			joint_s2   <= in_s1.joint;
			quot_in_s2 <= prod[PROD_W-1:PRE_SHIFT];
		end
		if (en3 && v_s2) begin
			joint_s3 <= joint_s2;
			rad_s3   <= qmul[DIV_SHIFT +: RAD_W];
		end
		if (en_out && v_s3) begin
			out_data_q.joint_out     <= joint_s3;
			out_data_q.angle_radians <= angle;
			out_data_q.negative      <= angle[ANGLE_W-1];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_plain_not_negative: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_data.joint_out != LAST_JOINT)) |-> !out_data.negative)
		else $error("negative result on a joint without unwrap");

	a_plain_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_data.joint_out != LAST_JOINT))
		|-> (out_data.angle_radians <= ANGLE_W'(TWO_PI_Q16)))
		else $error("plain joint angle above two pi");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ready)
		else $error("input stalled with an empty first stage");

	a_stage_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && en_out) |=> out_valid)
		else $error("final stage transaction lost on the way to the output");

endmodule

[tb/joint_angle_zero_wrap_unwrap_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for joint_angle_zero_wrap_unwrap_unit: an in-order scoreboard
// predicts each result from the joint's zero point and the last-joint unwrap state.
// Depends on jazw_pkg and the unit under test.
module joint_angle_zero_wrap_unwrap_unit_test;
	import jazw_pkg::*;

	class angle_scoreboard;
		localparam longint ANGLE_MAX = 64'sd2147483647;
		localparam longint ANGLE_MIN = -64'sd2147483648;

		logic [DEG_W-1:0]   zero_deg [8] = '{default: '0};
		logic signed [31:0] unwrap_sum = '0;
		logic [RAD_W-1:0]   unwrap_last = '0;
		bit                 unwrap_seeded = 0;
		out_t               expected_q [$];
		int unsigned        errors = 0;

		function void write_zero(int unsigned idx, logic [DEG_W-1:0] value);
			if (idx < ZP_COUNT) begin
				zero_deg[idx] = value;
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function void note_input(in_t item);
			longint zp, diff, rad, inv, delta, result;
			out_t e;
			zp = 0;
			if (item.joint < NUM_JOINTS) begin
				zp = longint'(zero_deg[item.joint]);
			end
			diff = longint'(item.raw_degrees) - zp;
			if (diff < -DEG_Q8_180) begin
				diff += DEG_Q8_360;
			end else if (diff > DEG_Q8_180) begin
				diff -= DEG_Q8_360;
			end
			diff += DEG_Q8_180;
			rad = (diff * PI_Q16 + ROUND_HALF) / DEG_Q8_180;
			result = rad;
			if (item.joint == LAST_JOINT) begin
				inv = TWO_PI_Q16 - rad;
				if (inv >= TWO_PI_Q16) begin
					inv -= TWO_PI_Q16;
				end
				if (!unwrap_seeded) begin
					result = inv;
					unwrap_seeded = 1;
				end else begin
					delta = inv - longint'(unwrap_last);
					if (delta > PI_Q16) begin
						delta -= TWO_PI_Q16;
					end else if (delta < -PI_Q16) begin
						delta += TWO_PI_Q16;
					end
					result = longint'(unwrap_sum) + delta;
					if (result > ANGLE_MAX) begin
						result = ANGLE_MAX;
					end
					if (result < ANGLE_MIN) begin
						result = ANGLE_MIN;
					end
				end
				unwrap_sum = result[31:0];
				unwrap_last = inv[RAD_W-1:0];
			end
			e.joint_out = item.joint;
			e.angle_radians = result[31:0];
			e.negative = (result < 0);
			expected_q.push_back(e);
		endfunction

		function void check_result(out_t got);
			out_t e;
			if (expected_q.size() == 0) begin
				$error("result for joint %0d arrived with no transaction outstanding",
					got.joint_out);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (got.joint_out !== e.joint_out) begin
				$error("joint_out: expected %0d, got %0d", e.joint_out, got.joint_out);
				errors++;
			end
			if (got.angle_radians !== e.angle_radians) begin
				$error("angle_radians: expected %0d, got %0d", e.angle_radians,
					got.angle_radians);
				errors++;
			end
			if (got.negative !== e.negative) begin
				$error("negative: expected %0d, got %0d", e.negative, got.negative);
				errors++;
			end
		endfunction
	endclass

	typedef enum {ZP_RANDOM, ZP_TOP, ZP_CLEAR, ZP_WIDE} zp_style_t;

	localparam int RAMP_STEP = 45824;

	logic                 clk = 0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_t                  in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_t                 out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DEG_W-1:0]     cfg_data;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	bit          hold_req = 0;

	angle_scoreboard sb = new;

	joint_angle_zero_wrap_unwrap_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_result(out_data);
		end
	end

	// The receiver counts a long hold-off itself once one is requested.
	initial begin
		int hold_left;
		hold_left = 0;
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				out_ready = 0;
				hold_left--;
			end else begin
				out_ready = ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic send_item(input in_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 0;
			@(negedge clk);
		end
		in_valid = 1;
		in_data = item;
		do @(posedge clk); while (!in_ready);
		sb.note_input(item);
		@(negedge clk);
	endtask

	task automatic offer_angle(input int unsigned joint, input int unsigned raw);
		in_t s;
		s.joint = JOINT_W'(joint);
		s.raw_degrees = DEG_W'(raw);
		send_item(s);
	endtask

	task automatic write_zero_point(input int unsigned idx, input int unsigned value);
		cfg_valid = 1;
		cfg_index = CFG_IDX_W'(idx);
		cfg_data = DEG_W'(value);
		do @(posedge clk); while (!cfg_ready);
		sb.write_zero(idx, DEG_W'(value));
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic wait_drained();
		in_valid = 0;
		while (sb.pending() != 0) begin
			@(negedge clk);
		end
		repeat (8) @(negedge clk);
	endtask

	task automatic configure_zero_points(input zp_style_t style);
		int unsigned v;
		wait_drained();
		for (int j = 0; j < ZP_COUNT; j++) begin
			case (style)
				ZP_TOP:   v = DEG_Q8_360;
				ZP_CLEAR: v = 0;
				ZP_WIDE:  v = $urandom_range((1 << DEG_W) - 1);
				default:  v = $urandom_range(DEG_Q8_360);
			endcase
			write_zero_point(j, v);
		end
	endtask

	function automatic in_t random_sample();
		in_t s;
		s.joint = ($urandom_range(99) < 40) ? LAST_JOINT : JOINT_W'($urandom_range(7));
		case ($urandom_range(9))
			0: s.raw_degrees = DEG_W'($urandom_range((1 << DEG_W) - 1));
			1: begin
				case ($urandom_range(3))
					0: s.raw_degrees = '0;
					1: s.raw_degrees = DEG_W'(DEG_Q8_180);
					2: s.raw_degrees = DEG_W'(DEG_Q8_360);
					default: s.raw_degrees = '1;
				endcase
			end
			default: s.raw_degrees = DEG_W'($urandom_range(DEG_Q8_360));
		endcase
		return s;
	endfunction

	task automatic run_phase(input int unsigned count, input int unsigned idle,
			input int unsigned stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		repeat (count) send_item(random_sample());
	endtask

	// Steps of 179 degrees keep every delta between consecutive ramp samples just inside
	// half a turn, so the unwrapped angle walks steadily in one direction.
	task automatic ramp_last_joint(input int unsigned steps, input bit upward);
		int raw;
		raw = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (steps) begin
			if (upward) begin
				raw = (raw + DEG_Q8_360 - RAMP_STEP) % DEG_Q8_360;
			end else begin
				raw = (raw + RAMP_STEP) % DEG_Q8_360;
			end
			offer_angle(LAST_JOINT, raw);
		end
	endtask

	initial begin
		in_valid = 0;
		in_data = '0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 0;
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		offer_angle(0, 0);
		offer_angle(0, DEG_Q8_180);
		offer_angle(0, DEG_Q8_180 + 1);
		offer_angle(0, DEG_Q8_360);
		offer_angle(0, (1 << DEG_W) - 1);
		offer_angle(1, 1);
		offer_angle(2, 65535);
		offer_angle(3, 65536);
		offer_angle(4, 100000);
		offer_angle(LAST_JOINT, 0);
		offer_angle(LAST_JOINT, DEG_Q8_180);
		offer_angle(LAST_JOINT, DEG_Q8_360);
		offer_angle(LAST_JOINT, (1 << DEG_W) - 1);
		offer_angle(NUM_JOINTS, 77777);
		offer_angle(NUM_JOINTS + 1, (1 << DEG_W) - 1);
		offer_angle(NUM_JOINTS + 1, 0);

		wait_drained();
		write_zero_point(0, DEG_Q8_360);
		write_zero_point(1, (1 << DEG_W) - 1);
		write_zero_point(LAST_JOINT, DEG_Q8_180);
		write_zero_point(ZP_COUNT, 1234);
		write_zero_point(ZP_COUNT + 1, 99999);
		offer_angle(0, 0);
		offer_angle(1, 0);
		offer_angle(LAST_JOINT, 0);
		offer_angle(LAST_JOINT, DEG_Q8_360);
		offer_angle(NUM_JOINTS, 3);
		offer_angle(NUM_JOINTS + 1, DEG_Q8_360);

		configure_zero_points(ZP_RANDOM);
		run_phase(180, 0, 0);
		configure_zero_points(ZP_TOP);
		run_phase(180, 74, 0);
		configure_zero_points(ZP_CLEAR);
		run_phase(180, 0, 74);
		configure_zero_points(ZP_WIDE);
		run_phase(180, 15, 15);

		configure_zero_points(ZP_RANDOM);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1;
		repeat (120) send_item(random_sample());

		ramp_last_joint(30, 1);
		ramp_last_joint(30, 0);

		wait_drained();
		if (sb.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
